// File: rtl/core/rvd_pkg.sv
package rvd_pkg;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MEXT = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SRL = 3'd5;

    localparam logic [11:0] SYS_ECALL  = 12'd0;
    localparam logic [11:0] SYS_EBREAK = 12'd1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_R   = 3'd1;
    localparam logic [2:0] ST_BAD_SH  = 3'd2;
    localparam logic [2:0] ST_BAD_LD  = 3'd3;
    localparam logic [2:0] ST_BAD_ST  = 3'd4;
    localparam logic [2:0] ST_BAD_BR  = 3'd5;
    localparam logic [2:0] ST_PRIV    = 3'd6;
    localparam logic [2:0] ST_BAD_OPC = 3'd7;

    localparam logic PK_OTHER = 1'b0;
    localparam logic PK_CSR   = 1'b1;

    localparam logic [5:0] MN_NONE   = 6'd0;
    localparam logic [5:0] MN_ADD    = 6'd1;
    localparam logic [5:0] MN_SUB    = 6'd2;
    localparam logic [5:0] MN_MUL    = 6'd3;
    localparam logic [5:0] MN_SLL    = 6'd4;
    localparam logic [5:0] MN_MULH   = 6'd5;
    localparam logic [5:0] MN_SLT    = 6'd6;
    localparam logic [5:0] MN_MULHSU = 6'd7;
    localparam logic [5:0] MN_SLTU   = 6'd8;
    localparam logic [5:0] MN_MULHU  = 6'd9;
    localparam logic [5:0] MN_XOR    = 6'd10;
    localparam logic [5:0] MN_DIV    = 6'd11;
    localparam logic [5:0] MN_SRL    = 6'd12;
    localparam logic [5:0] MN_SRA    = 6'd13;
    localparam logic [5:0] MN_DIVU   = 6'd14;
    localparam logic [5:0] MN_OR     = 6'd15;
    localparam logic [5:0] MN_REM    = 6'd16;
    localparam logic [5:0] MN_AND    = 6'd17;
    localparam logic [5:0] MN_REMU   = 6'd18;
    localparam logic [5:0] MN_ADDI   = 6'd19;
    localparam logic [5:0] MN_SLLI   = 6'd20;
    localparam logic [5:0] MN_SLTI   = 6'd21;
    localparam logic [5:0] MN_SLTIU  = 6'd22;
    localparam logic [5:0] MN_XORI   = 6'd23;
    localparam logic [5:0] MN_SRLI   = 6'd24;
    localparam logic [5:0] MN_SRAI   = 6'd25;
    localparam logic [5:0] MN_ORI    = 6'd26;
    localparam logic [5:0] MN_ANDI   = 6'd27;
    localparam logic [5:0] MN_LB     = 6'd28;
    localparam logic [5:0] MN_LH     = 6'd29;
    localparam logic [5:0] MN_LW     = 6'd30;
    localparam logic [5:0] MN_LBU    = 6'd31;
    localparam logic [5:0] MN_LHU    = 6'd32;
    localparam logic [5:0] MN_SB     = 6'd33;
    localparam logic [5:0] MN_SH     = 6'd34;
    localparam logic [5:0] MN_SW     = 6'd35;
    localparam logic [5:0] MN_BEQ    = 6'd36;
    localparam logic [5:0] MN_BNE    = 6'd37;
    localparam logic [5:0] MN_BLT    = 6'd38;
    localparam logic [5:0] MN_BGE    = 6'd39;
    localparam logic [5:0] MN_BLTU   = 6'd40;
    localparam logic [5:0] MN_BGEU   = 6'd41;
    localparam logic [5:0] MN_JALR   = 6'd42;
    localparam logic [5:0] MN_JAL    = 6'd43;
    localparam logic [5:0] MN_LUI    = 6'd44;
    localparam logic [5:0] MN_AUIPC  = 6'd45;
    localparam logic [5:0] MN_ECALL  = 6'd46;
    localparam logic [5:0] MN_EBREAK = 6'd47;

    typedef struct packed {
        logic [5:0]         mnemonic;
        logic [2:0]         status;
        logic               privileged_kind;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic [31:0]        target_addr;
        logic [6:0]         opcode_field;
        logic [2:0]         funct3_field;
        logic [6:0]         funct7_field;
    } dec_result_t;

    function automatic logic [5:0] r_base_code(input logic [2:0] f3);
        logic [5:0] mn;
        case (f3)
            3'd0:    mn = MN_ADD;
            3'd1:    mn = MN_SLL;
            3'd2:    mn = MN_SLT;
            3'd3:    mn = MN_SLTU;
            3'd4:    mn = MN_XOR;
            3'd5:    mn = MN_SRL;
            3'd6:    mn = MN_OR;
            3'd7:    mn = MN_AND;
            default: mn = MN_NONE;
        endcase
        return mn;
    endfunction

    function automatic logic [5:0] r_mext_code(input logic [2:0] f3);
        logic [5:0] mn;
        case (f3)
            3'd0:    mn = MN_MUL;
            3'd1:    mn = MN_MULH;
            3'd2:    mn = MN_MULHSU;
            3'd3:    mn = MN_MULHU;
            3'd4:    mn = MN_DIV;
            3'd5:    mn = MN_DIVU;
            3'd6:    mn = MN_REM;
            3'd7:    mn = MN_REMU;
            default: mn = MN_NONE;
        endcase
        return mn;
    endfunction

    function automatic logic [5:0] opimm_code(input logic [2:0] f3);
        logic [5:0] mn;
        case (f3)
            3'd0:    mn = MN_ADDI;
            3'd1:    mn = MN_SLLI;
            3'd2:    mn = MN_SLTI;
            3'd3:    mn = MN_SLTIU;
            3'd4:    mn = MN_XORI;
            3'd6:    mn = MN_ORI;
            3'd7:    mn = MN_ANDI;
            default: mn = MN_NONE;
        endcase
        return mn;
    endfunction

    function automatic logic [5:0] load_code(input logic [2:0] f3);
        logic [5:0] mn;
        case (f3)
            3'd0:    mn = MN_LB;
            3'd1:    mn = MN_LH;
            3'd2:    mn = MN_LW;
            3'd4:    mn = MN_LBU;
            3'd5:    mn = MN_LHU;
            default: mn = MN_NONE;
        endcase
        return mn;
    endfunction

    function automatic logic [5:0] store_code(input logic [2:0] f3);
        logic [5:0] mn;
        case (f3)
            3'd0:    mn = MN_SB;
            3'd1:    mn = MN_SH;
            3'd2:    mn = MN_SW;
            default: mn = MN_NONE;
        endcase
        return mn;
    endfunction

    function automatic logic [5:0] branch_code(input logic [2:0] f3);
        logic [5:0] mn;
        case (f3)
            3'd0:    mn = MN_BEQ;
            3'd1:    mn = MN_BNE;
            3'd4:    mn = MN_BLT;
            3'd5:    mn = MN_BGE;
            3'd6:    mn = MN_BLTU;
            3'd7:    mn = MN_BGEU;
            default: mn = MN_NONE;
        endcase
        return mn;
    endfunction

endpackage

// File: rtl/core/rvd_in_if.sv
interface rvd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_pc;
    logic [31:0] instr_word;

    modport source (output valid, output instr_pc, output instr_word, input ready);
    modport sink   (input valid, input instr_pc, input instr_word, output ready);
endinterface

// File: rtl/core/rvd_out_if.sv
interface rvd_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         mnemonic;
    logic [2:0]         status;
    logic               privileged_kind;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        target_addr;
    logic [6:0]         opcode_field;
    logic [2:0]         funct3_field;
    logic [6:0]         funct7_field;

    modport source (
        output valid, output mnemonic, output status, output privileged_kind,
        output dest_reg, output src1_reg, output src2_reg, output immediate,
        output target_addr, output opcode_field, output funct3_field,
        output funct7_field, input ready
    );
    modport sink (
        input valid, input mnemonic, input status, input privileged_kind,
        input dest_reg, input src1_reg, input src2_reg, input immediate,
        input target_addr, input opcode_field, input funct3_field,
        input funct7_field, output ready
    );
endinterface

// File: rtl/core/rvd_decode.sv
module rvd_decode (
    input  logic [31:0]        instr_pc,
    input  logic [31:0]        instr_word,
    output rvd_pkg::dec_result_t result
);
    import rvd_pkg::*;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rs2;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] shamt;
    logic [5:0]  mn;
    logic [2:0]  st;
    logic        pk;
    logic [31:0] imm;
    logic        use_target;

    assign opc   = instr_word[6:0];
    assign f3    = instr_word[14:12];
    assign f7    = instr_word[31:25];
    assign rs2   = instr_word[24:20];
    assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
    assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
    assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                    instr_word[30:25], instr_word[11:8], 1'b0};
    assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                    instr_word[20], instr_word[30:21], 1'b0};
    assign shamt = {27'd0, rs2};

    always_comb
    begin
        mn         = MN_NONE;
        st         = ST_OK;
        pk         = PK_OTHER;
        imm        = 32'd0;
        use_target = 1'b0;
        case (opc)
            OPC_OP:
            begin
                if (f7 == F7_BASE)
                    mn = r_base_code(f3);
                else if (f7 == F7_MEXT)
                    mn = r_mext_code(f3);
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    mn = MN_SUB;
                else if (f7 == F7_ALT && f3 == F3_SRL)
                    mn = MN_SRA;
                if (mn == MN_NONE)
                    st = ST_BAD_R;
            end
            OPC_OPIMM:
            begin
                if (f3 == F3_SLL)
                begin
                    imm = shamt;
                    mn  = MN_SLLI;
                end
                else if (f3 == F3_SRL)
                begin
                    imm = shamt;
                    if (f7 == F7_BASE)
                        mn = MN_SRLI;
                    else if (f7 == F7_ALT)
                        mn = MN_SRAI;
                    else
                        st = ST_BAD_SH;
                end
                else
                begin
                    imm = imm_i;
                    mn  = opimm_code(f3);
                end
            end
            OPC_LOAD:
            begin
                imm = imm_i;
                mn  = load_code(f3);
                if (mn == MN_NONE)
                    st = ST_BAD_LD;
            end
            OPC_STORE:
            begin
                imm = imm_s;
                mn  = store_code(f3);
                if (mn == MN_NONE)
                    st = ST_BAD_ST;
            end
            OPC_BRANCH:
            begin
                imm        = imm_b;
                use_target = 1'b1;
                mn         = branch_code(f3);
                if (mn == MN_NONE)
                    st = ST_BAD_BR;
            end
            OPC_JALR:
            begin
                imm = imm_i;
                mn  = MN_JALR;
            end
            OPC_JAL:
            begin
                imm        = imm_j;
                use_target = 1'b1;
                mn         = MN_JAL;
            end
            OPC_LUI:
            begin
                imm = instr_word & UPPER_MASK;
                mn  = MN_LUI;
            end
            OPC_AUIPC:
            begin
                imm = instr_word & UPPER_MASK;
                mn  = MN_AUIPC;
            end
            OPC_SYSTEM:
            begin
                imm = imm_i;
                if (f3 == F3_ADD)
                begin
                    if (instr_word[31:20] == SYS_ECALL)
                        mn = MN_ECALL;
                    else if (instr_word[31:20] == SYS_EBREAK)
                        mn = MN_EBREAK;
                    else
                        st = ST_PRIV;
                end
                else
                begin
                    st = ST_PRIV;
                    pk = PK_CSR;
                end
            end
            default:
            begin
                st = ST_BAD_OPC;
            end
        endcase
    end

    always_comb
    begin
        result.mnemonic        = mn;
        result.status          = st;
        result.privileged_kind = pk;
        result.dest_reg        = instr_word[11:7];
        result.src1_reg        = instr_word[19:15];
        result.src2_reg        = rs2;
        result.immediate       = imm;
        result.target_addr     = use_target ? (instr_pc + imm) : 32'd0;
        result.opcode_field    = opc;
        result.funct3_field    = f3;
        result.funct7_field    = f7;
    end

endmodule

// File: rtl/core/rv32im_instruction_decoder.sv
// RV32IM instruction decoder.
// An accepted request is registered in the input register, then decoded into the result
// register. Throughput: one request per cycle while dec_out.ready is not held low;
// each register stage loads while the one after it drains.
// Reset: rst_n clears both stage valid flags; payload registers are not reset.
module rv32im_instruction_decoder (
    input  logic        clk,
    input  logic        rst_n,
    rvd_in_if.sink      inst_in,
    rvd_out_if.source   dec_out
);
    import rvd_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] s1_pc_reg;
    logic [31:0] s1_word_reg;
    logic        s2_valid_reg;
    logic        s2_valid_next;
    dec_result_t s2_res_reg;
    dec_result_t s2_res_next;
    logic        s1_ready;
    logic        s2_ready;

    assign s2_ready      = !s2_valid_reg || dec_out.ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign inst_in.ready = s1_ready;

    assign s1_valid_next = s1_ready ? inst_in.valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    rvd_decode u_decode (
        .instr_pc   (s1_pc_reg),
        .instr_word (s1_word_reg),
        .result     (s2_res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // load payload only on an advance; hold otherwise
    always_ff @(posedge clk)
    begin
        if (s1_ready && inst_in.valid)
        begin
            s1_pc_reg   <= inst_in.instr_pc;
            s1_word_reg <= inst_in.instr_word;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_res_reg <= s2_res_next;
        end
    end

    assign dec_out.valid           = s2_valid_reg;
    assign dec_out.mnemonic        = s2_res_reg.mnemonic;
    assign dec_out.status          = s2_res_reg.status;
    assign dec_out.privileged_kind = s2_res_reg.privileged_kind;
    assign dec_out.dest_reg        = s2_res_reg.dest_reg;
    assign dec_out.src1_reg        = s2_res_reg.src1_reg;
    assign dec_out.src2_reg        = s2_res_reg.src2_reg;
    assign dec_out.immediate       = s2_res_reg.immediate;
    assign dec_out.target_addr     = s2_res_reg.target_addr;
    assign dec_out.opcode_field    = s2_res_reg.opcode_field;
    assign dec_out.funct3_field    = s2_res_reg.funct3_field;
    assign dec_out.funct7_field    = s2_res_reg.funct7_field;

endmodule
